/* design/hmog_pkg.sv */
// Shared types and constants for the height map obstacle grid.
// Holds the command and result structs, the cell entry layout and the control codes.
// No dependencies.
`default_nettype none

package hmog_pkg;

	localparam int CELL_W = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_CELL_RECIP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_DIFF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NEGATIVE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BACK_ROWS = 2'd3;

	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_READ = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CS_UNKNOWN = 2'd0,
		CS_CLEAR = 2'd1,
		CS_OBSTACLE = 2'd2
	} cell_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DRAIN,
		S_CLEAR,
		S_READ
	} fsm_t;

	typedef struct packed {
		logic [1:0] action;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic signed [15:0] point_z;
		logic [CELL_W-1:0] row_sel;
	} cmd_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_x;
		logic [CELL_W-1:0] cell_y;
		logic [1:0] status;
		logic last;
	} result_t;

	typedef struct packed {
		logic seen;
		logic signed [15:0] low;
		logic signed [15:0] high;
	} cell_t;

endpackage

`default_nettype wire

/* design/height_map_obstacle_grid.sv */
// Top level of the height map obstacle grid: point binning pipeline, cell memory,
// clear sweep and row readout. Depends on hmog_pkg.
`default_nettype none

// The block bins lidar points into a square grid and reports per-cell status.
// Commands arrive on cmd: a transaction is accepted at a rising edge with start
// high and busy low. An add-point transaction enters a four-stage pipeline
// (input register, multiply, index and memory read, merge and write back) and
// busy stays low, so points are taken one per cycle. A read-modify-write of the
// same cell by back-to-back points is resolved by forwarding the last write.
// A clear or read-row transaction raises busy, first waits until the point
// pipeline has drained, then runs. Clear rewrites every entry of the cell memory,
// one per cycle; there are 2^(2*clog2(GRID_CELLS)) entries, 4096 at the default
// size. Read-row reads one column per cycle from the memory port and emits
// GRID_CELLS results on consecutive cycles, each marked by a one-cycle
// result_valid; each result passes the memory read register and the result
// register, and last marks the final column.
// The receiver cannot stall results.
// After reset the block runs the same clearing pass (busy high) before it takes
// any command. Configuration writes are taken at any time on cfg_valid, with
// cfg_ready tied high; they are meant to change only while the block is idle.
module height_map_obstacle_grid
	import hmog_pkg::*;
#(
	parameter int GRID_CELLS = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire cmd_t cmd,
	output logic result_valid,
	output result_t result,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDXW = $clog2(GRID_CELLS);
	localparam int ADDRW = 2 * IDXW;
	localparam int DEPTH = 1 << ADDRW;
	localparam logic signed [33:0] HALF_Q = 34'((GRID_CELLS / 2) * 65536);
	localparam logic signed [33:0] NEG_ONE_Q = -34'sd65536;
	localparam logic [IDXW-1:0] COL_LAST = IDXW'(GRID_CELLS - 1);
	localparam logic signed [8:0] HALF_ROWS = 9'(GRID_CELLS / 2);

	typedef struct packed {
		logic ok;
		logic [IDXW-1:0] idx;
	} bin_t;

	// Truncation toward zero of the scaled sum, with the off-grid check. Any sum in
	// (-1, 0) truncates to index zero and stays on the grid.
	function automatic bin_t bin_index(input logic signed [33:0] s);
		bin_t b;
		b.ok = s[33] ? (s > NEG_ONE_Q) : (s[32:16] < 17'(GRID_CELLS));
		b.idx = s[33] ? '0 : s[16 +: IDXW];
		return b;
	endfunction

	// Configuration registers.
	logic [15:0] recip_q;
	logic [14:0] hdiff_q;
	logic signed [15:0] neg_q;
	logic [6:0] back_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recip_q <= 16'd437;
			hdiff_q <= 15'd500;
			neg_q <= -16'sd500;
			back_q <= 7'd20;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CELL_RECIP: recip_q <= cfg_data;
				REG_HEIGHT_DIFF: hdiff_q <= cfg_data[14:0];
				REG_NEGATIVE: neg_q <= $signed(cfg_data);
				REG_BACK_ROWS: back_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Control state.
	fsm_t state_q, state_d;
	logic pend_clear_q;
	logic [CELL_W-1:0] row_q;
	logic [IDXW-1:0] col_q;
	logic [ADDRW-1:0] sweep_q;

	logic accept;
	logic sweep_we;
	logic rr_issue;
	logic pipe_empty;

	logic v_s1, v_s2, v_s3;

	assign accept = start && !busy;
	assign pipe_empty = !v_s1 && !v_s2 && !v_s3;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (cmd.action == ACT_CLEAR || cmd.action == ACT_READ)) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (pipe_empty) begin
					state_d = pend_clear_q ? S_CLEAR : S_READ;
				end
			end
			S_CLEAR: begin
				if (sweep_q == '1) begin
					state_d = S_IDLE;
				end
			end
			S_READ: begin
				if (col_q == COL_LAST) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b1;
		sweep_we = 1'b0;
		rr_issue = 1'b0;
		unique case (state_q)
			S_IDLE: busy = 1'b0;
			S_DRAIN: ;
			S_CLEAR: sweep_we = 1'b1;
			S_READ: rr_issue = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			pend_clear_q <= 1'b0;
			row_q <= '0;
			col_q <= '0;
			sweep_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				pend_clear_q <= (cmd.action == ACT_CLEAR);
				row_q <= cmd.row_sel;
			end
			if (sweep_we) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (rr_issue) begin
				col_q <= (col_q == COL_LAST) ? '0 : col_q + 1'b1;
			end
		end
	end

	// Point pipeline, stage 1: captured point.
	logic signed [15:0] px_s1, py_s1, pz_s1;
	// Stage 2: scaled coordinates.
	logic signed [32:0] prodx_s2, prody_s2;
	logic signed [15:0] pz_s2;
	// Stage 3: cell address and height, memory data arrives here.
	logic [ADDRW-1:0] addr_s3;
	logic signed [15:0] pz_s3;

	bin_t bx, by;

	assign bx = bin_index($signed({prodx_s2[32], prodx_s2}) + HALF_Q);
	assign by = bin_index($signed({prody_s2[32], prody_s2}) + HALF_Q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept && (cmd.action == ACT_ADD);
			v_s2 <= v_s1;
			v_s3 <= v_s2 && bx.ok && by.ok;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= cmd.point_x;
		py_s1 <= cmd.point_y;
		pz_s1 <= cmd.point_z;
		prodx_s2 <= 33'(px_s1) * 33'($signed({1'b0, recip_q}));
		prody_s2 <= 33'(py_s1) * 33'($signed({1'b0, recip_q}));
		pz_s2 <= pz_s1;
		addr_s3 <= {bx.idx, by.idx};
		pz_s3 <= pz_s2;
	end

	// Cell memory: one read port, one write port, registered read data.
	cell_t mem [DEPTH];
	cell_t rd_q;
	logic [ADDRW-1:0] rd_addr;
	logic we;
	logic [ADDRW-1:0] waddr;
	cell_t wdata;

	// Merge stage with forwarding of the previous point's write, held in wr_data_q,
	// whose data the read made in that same cycle could not yet see.
	logic wr_v_q;
	logic [ADDRW-1:0] wr_addr_q;
	cell_t wr_data_q;
	cell_t old_cell, new_cell;

	always_comb begin
		old_cell = (wr_v_q && wr_addr_q == addr_s3) ? wr_data_q : rd_q;
		new_cell.seen = 1'b1;
		if (!old_cell.seen) begin
			new_cell.low = pz_s3;
			new_cell.high = pz_s3;
		end else begin
			new_cell.low = (pz_s3 < old_cell.low) ? pz_s3 : old_cell.low;
			new_cell.high = (pz_s3 > old_cell.high) ? pz_s3 : old_cell.high;
		end
	end

	assign rd_addr = rr_issue ? {row_q[IDXW-1:0], col_q} : {bx.idx, by.idx};
	assign we = v_s3 || sweep_we;
	assign waddr = sweep_we ? sweep_q : addr_s3;
	assign wdata = sweep_we ? '0 : new_cell;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[rd_addr];
		wr_addr_q <= addr_s3;
		wr_data_q <= new_cell;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_v_q <= 1'b0;
		end else begin
			wr_v_q <= v_s3;
		end
	end

	// Row readout: issue stage, then status stage into the result register.
	logic rr_v_s1;
	logic [CELL_W-1:0] rr_row_s1;
	logic [IDXW-1:0] rr_col_s1;
	logic rr_oob_s1;
	logic rr_before_s1;
	logic signed [8:0] start_row;
	logic signed [16:0] spread;
	logic [1:0] status_d;

	assign start_row = HALF_ROWS - $signed({2'b00, back_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rr_v_s1 <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			rr_v_s1 <= rr_issue;
			result_valid <= rr_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		rr_row_s1 <= row_q;
		rr_col_s1 <= col_q;
		rr_oob_s1 <= ({1'b0, row_q} >= 7'(GRID_CELLS));
		rr_before_s1 <= ($signed({3'b000, row_q}) < start_row);
	end

	always_comb begin
		spread = $signed({rd_q.high[15], rd_q.high}) - $signed({rd_q.low[15], rd_q.low});
		if (rr_oob_s1 || rr_before_s1 || !rd_q.seen) begin
			status_d = CS_UNKNOWN;
		end else if (spread > $signed({2'b00, hdiff_q}) || rd_q.high < neg_q) begin
			status_d = CS_OBSTACLE;
		end else begin
			status_d = CS_CLEAR;
		end
	end

	always_ff @(posedge clk) begin
		result.cell_x <= rr_row_s1;
		result.cell_y <= CELL_W'(rr_col_s1);
		result.status <= status_d;
		result.last <= (rr_col_s1 == COL_LAST);
	end

	// The point pipeline and the clearing sweep never share the write port.
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s3 && state_q == S_CLEAR))
		else $error("point write during clearing sweep");

	// Row readout only runs once the point pipeline has drained.
	a_read_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> (!v_s2 && !v_s3))
		else $error("row readout overlaps point pipeline");

	// The final column of a row is followed by a gap before any further result.
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |=> !result_valid)
		else $error("result directly after last column");

	// Results of one row come on consecutive cycles until the last column.
	a_row_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=> result_valid)
		else $error("gap inside a row readout");

endmodule

`default_nettype wire
